### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the packed bit-field store.
// Depends on nothing; the SYNTH macro removes the checks from synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check on every rising clock edge, off while reset is asserted
`define PBS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising clock edge, reset included
`define PBS_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PBS_ASSERT(name, clk, rst_n, prop, msg)
`define PBS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### rtl/core/pbs_pkg.sv
// Types and constants of the packed bit-field store.
// Used by packed_bitfield_store; depends on nothing.
package pbs_pkg;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef struct packed {
		logic        req_type;
		logic [10:0] bit_offset;
		logic [5:0]  field_width;
		logic [31:0] write_value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        status;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_MERGE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage

### rtl/core/packed_bitfield_store.sv
// Packed bit-field store: byte memory with bit-field read and write.
// Sequence: zero-width or out-of-range beats go from accept straight to the done step,
// else the field is walked with one byte per read/merge pair, then the done step.
// Throughput: one beat at a time; the next beat is taken the cycle after the result loads.
// Reset: a clearing pass writes zero to every byte of the memory, req_stall held high meanwhile.
// Depends on pbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module packed_bitfield_store #(
	parameter int STORE_BYTES    = 256,
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pbs_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pbs_pkg::rsp_t  rsp
);
	import pbs_pkg::*;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int LIMIT  = STORE_BYTES * 8;
	localparam int LIM_W  = $clog2(LIMIT + 1);
	localparam int CMP_W  = (LIM_W > 12) ? LIM_W : 12;
	localparam int SH_W   = $clog2(MAX_FIELD_BITS + 1);

	logic [7:0] mem [STORE_BYTES];

	state_t                    state_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [5:0]                rem_q;
	logic [2:0]                js_q;
	logic                      is_write_q;
	logic                      err_q;
	logic [MAX_FIELD_BITS-1:0] acc_q;
	logic [MAX_FIELD_BITS-1:0] wsh_q;
	logic [7:0]                rd_data_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	logic                       accept;
	logic                       slot_free;
	logic [CMP_W-1:0]           end_sum;
	logic                       range_err;
	logic [ADDR_W+7:0]          start_ext;
	logic [MAX_FIELD_BITS+31:0] wval_ext;
	logic [SH_W-1:0]            align_sh;
	logic [3:0]                 avail;
	logic [3:0]                 n_bits;
	logic [3:0]                 byte_sh;
	logic [7:0]                 n_mask;
	logic [7:0]                 field_bits;
	logic [7:0]                 ins_bits;
	logic [7:0]                 new_byte;
	logic [5:0]                 rem_next;
	logic [MAX_FIELD_BITS+31:0] acc_ext;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign end_sum   = CMP_W'(req.bit_offset) + CMP_W'(req.field_width);
	assign range_err = (end_sum > CMP_W'(LIMIT)) ||
		(req.field_width > 6'(MAX_FIELD_BITS > 63 ? 63 : MAX_FIELD_BITS));
	assign start_ext = {ADDR_W'(0), req.bit_offset[10:3]};
	assign wval_ext  = {MAX_FIELD_BITS'(0), req.write_value};
	assign align_sh  = SH_W'(MAX_FIELD_BITS) - SH_W'(req.field_width);

	// shared byte unit: slice, extract and merge one byte of the field
	assign avail      = 4'd8 - {1'b0, js_q};
	assign n_bits     = ({2'b00, avail} > rem_q) ? rem_q[3:0] : avail;
	assign byte_sh    = avail - n_bits;
	assign n_mask     = BYTE_MASK >> (4'd8 - n_bits);
	assign field_bits = (rd_data_q >> byte_sh) & n_mask;
	assign ins_bits   = wsh_q[MAX_FIELD_BITS-1 -: 8] >> (4'd8 - n_bits);
	assign new_byte   = (rd_data_q & ~(n_mask << byte_sh)) | ((ins_bits & n_mask) << byte_sh);
	assign rem_next   = rem_q - 6'(n_bits);
	assign acc_ext    = {32'(0), acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						addr_q <= start_ext[ADDR_W-1:0];
						if (range_err || req.field_width == 6'd0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					addr_q <= addr_q + 1'b1;
					if (rem_next == 6'd0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			is_write_q <= (req.req_type == REQ_WRITE);
			err_q      <= range_err;
			rem_q      <= req.field_width;
			js_q       <= req.bit_offset[2:0];
			acc_q      <= '0;
			wsh_q      <= wval_ext[MAX_FIELD_BITS-1:0] << align_sh;
		end else if (state_q == S_MERGE) begin
			rem_q <= rem_next;
			js_q  <= 3'd0;
			wsh_q <= wsh_q << n_bits;
			if (!is_write_q) begin
				acc_q <= (acc_q << n_bits) | MAX_FIELD_BITS'(field_bits);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem[addr_q] <= '0;
		end else if (state_q == S_MERGE && is_write_q) begin
			mem[addr_q] <= new_byte;
		end
		rd_data_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			rsp_q.status     <= err_q ? ST_RANGE : ST_OK;
			rsp_q.read_value <= (err_q || is_write_q) ? 32'd0 : acc_ext[31:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PBS_ASSERT(a_rem_live, clk, arst_n, (state_q == S_READ || state_q == S_MERGE) |-> rem_q != 6'd0, "byte step with no field bits left")
	`PBS_ASSERT(a_merge_after_read, clk, arst_n, state_q == S_MERGE |-> $past(state_q == S_READ), "merge without a preceding memory read")
	`PBS_ASSERT(a_accept_leaves_idle, clk, arst_n, accept |=> state_q != S_IDLE, "accepted beat did not start the sequencer")
	`PBS_ASSERT(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == S_DONE), "result loaded outside the done step")
	`PBS_ASSERT(a_err_zero, clk, arst_n, (rsp_valid_q && rsp_q.status == ST_RANGE) |-> rsp_q.read_value == 32'd0, "rejected beat returned a nonzero value")

endmodule
